FILE: design/fss_pkg.sv
// Shared types, constants and the segment table of the display serializer.
// Used by the front, back and top-level modules; depends on nothing.
package fss_pkg;

  // Command codes carried by the action field.
  localparam logic ACT_POWER_ON = 1'b0;
  localparam logic ACT_SHOW     = 1'b1;

  // Fixed command bytes of the display controller.
  localparam logic [7:0] CMD_BRIGHT_FULL = 8'h8F;
  localparam logic [7:0] CMD_DATA_AUTO   = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO   = 8'hC0;

  // Reciprocal of ten for a 16-bit dividend: q = (n * RECIP_TEN) >> RECIP_SHIFT.
  localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
  localparam int          RECIP_SHIFT = 19;

  // Byte positions within a show command: the command bytes, then four digits.
  localparam logic [2:0] BYTE_FIRST  = 3'd0;
  localparam logic [2:0] BYTE_ADDR   = 3'd1;
  localparam logic [2:0] BYTE_THOU   = 3'd2;
  localparam logic [2:0] BYTE_HUND   = 3'd3;
  localparam logic [2:0] BYTE_TENS   = 3'd4;
  localparam logic [2:0] BYTE_UNITS  = 3'd5;

  localparam int JOB_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } symbol_t;

  // One classified command: digits are thousands, hundreds, tens, units (MSB first).
  typedef struct packed {
    logic        action;
    logic [15:0] digits;
  } job_t;

  // One line symbol as it leaves the back end.
  typedef struct packed {
    symbol_t symbol;
    logic    bit_value;
    logic    last;
  } sym_word_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_START,
    BE_BIT,
    BE_ACK,
    BE_STOP
  } be_state_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0: pat = 8'h3F;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5B;
      4'd3: pat = 8'h4F;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6D;
      4'd6: pat = 8'h7D;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7F;
      4'd9: pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

FILE: design/fss_fifo.sv
// Small synchronous queue with full and empty flags.
// Used for the job queue and the output queue; depends on nothing.
module fss_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/fss_front.sv
// Front end: accepts commands; splits a show number into four decimal digits.
// Depends on fss_pkg; feeds the job queue.
module fss_front
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        action,
  input  logic [15:0] number,
  output logic        full,
  output logic        job_push,
  output job_t        job,
  input  logic        job_full
);

  fe_state_t   state;
  fe_state_t   state_next;
  logic        act;
  logic [15:0] rest;
  logic [15:0] digits;
  logic [1:0]  step;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] rem_full;
  logic        accept;

  // One decimal digit per cycle: divide by ten through the reciprocal.
  assign prod     = rest * RECIP_TEN;
  assign quot     = prod[31:RECIP_SHIFT];
  assign rem_full = rest - {quot, 3'b000} - {2'b00, quot, 1'b0};

  assign full      = (state != FE_IDLE);
  assign accept    = push && !full;
  assign job.action = act;
  assign job.digits = digits;

  always_comb begin
    state_next = state;
    job_push   = 1'b0;
    unique case (state)
      FE_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_SHOW) ? FE_CONV : FE_PUSH;
        end
      end
      FE_CONV: begin
        if (step == 2'd3) begin
          state_next = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!job_full) begin
          job_push   = 1'b1;
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == FE_CONV) begin
        step <= step + 1'b1;
      end
    end
  end

  // The units digit comes out first and is shifted down into place; a fifth
  // digit is never formed, which leaves the number modulo 10000.
  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= action;
      rest   <= number;
      digits <= '0;
    end else if (state == FE_CONV) begin
      rest   <= {3'b000, quot};
      digits <= {rem_full[3:0], digits[15:4]};
    end
  end

endmodule

FILE: design/fss_back.sv
// Back end: walks a job's line frames; one symbol per cycle unless stalled.
// Depends on fss_pkg; reads the job queue and writes the output queue.
module fss_back
  import fss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      job_in,
  input  logic      job_empty,
  output logic      job_pop,
  output logic      out_push,
  output sym_word_t out_word,
  input  logic      out_full
);

  be_state_t  state;
  be_state_t  state_next;
  job_t       job;
  logic [2:0] byte_idx;
  logic [2:0] byte_idx_next;
  logic [2:0] bit_cnt;
  logic [2:0] bit_cnt_next;
  logic [7:0] cur_byte;
  logic       emit;
  logic       second_frame;

  always_comb begin
    unique case (byte_idx)
      BYTE_FIRST: cur_byte = (job.action == ACT_SHOW) ? CMD_DATA_AUTO : CMD_BRIGHT_FULL;
      BYTE_ADDR:  cur_byte = CMD_ADDR_ZERO;
      BYTE_THOU:  cur_byte = seg_pattern(job.digits[15:12]);
      BYTE_HUND:  cur_byte = seg_pattern(job.digits[11:8]);
      BYTE_TENS:  cur_byte = seg_pattern(job.digits[7:4]);
      BYTE_UNITS: cur_byte = seg_pattern(job.digits[3:0]);
      default:    cur_byte = 8'h00;
    endcase
  end

  // A show command follows its first stop with the display frame.
  assign second_frame = (byte_idx == BYTE_FIRST) && (job.action == ACT_SHOW);
  assign emit         = (state != BE_IDLE) && !out_full;
  assign out_push     = emit;

  always_comb begin
    out_word.symbol    = SYM_START;
    out_word.bit_value = 1'b0;
    out_word.last      = 1'b0;
    unique case (state)
      BE_START: out_word.symbol = SYM_START;
      BE_BIT: begin
        out_word.symbol    = SYM_BIT;
        out_word.bit_value = cur_byte[bit_cnt];
      end
      BE_ACK:  out_word.symbol = SYM_ACK;
      BE_STOP: begin
        out_word.symbol = SYM_STOP;
        out_word.last   = !second_frame;
      end
      default: out_word.symbol = SYM_START;
    endcase
  end

  always_comb begin
    state_next    = state;
    byte_idx_next = byte_idx;
    bit_cnt_next  = bit_cnt;
    job_pop       = 1'b0;
    unique case (state)
      BE_IDLE: begin
        if (!job_empty) begin
          job_pop       = 1'b1;
          byte_idx_next = BYTE_FIRST;
          state_next    = BE_START;
        end
      end
      BE_START: begin
        if (emit) begin
          bit_cnt_next = '0;
          state_next   = BE_BIT;
        end
      end
      BE_BIT: begin
        if (emit) begin
          bit_cnt_next = bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            state_next = BE_ACK;
          end
        end
      end
      BE_ACK: begin
        if (emit) begin
          if (byte_idx == BYTE_FIRST || byte_idx == BYTE_UNITS) begin
            state_next = BE_STOP;
          end else begin
            byte_idx_next = byte_idx + 1'b1;
            bit_cnt_next  = '0;
            state_next    = BE_BIT;
          end
        end
      end
      BE_STOP: begin
        if (emit) begin
          if (second_frame) begin
            byte_idx_next = BYTE_ADDR;
            state_next    = BE_START;
          end else if (!job_empty) begin
            // Pick up the next job without returning to idle.
            job_pop       = 1'b1;
            byte_idx_next = BYTE_FIRST;
            state_next    = BE_START;
          end else begin
            state_next = BE_IDLE;
          end
        end
      end
      default: state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BE_IDLE;
      byte_idx <= '0;
      bit_cnt  <= '0;
    end else begin
      state    <= state_next;
      byte_idx <= byte_idx_next;
      bit_cnt  <= bit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
  end

endmodule

FILE: design/four_digit_segment_display_serializer.sv
// Top level of the two-wire seven-segment display serializer.
// Depends on fss_pkg, fss_front, fss_fifo and fss_back.
//
//   channel   ports                               handshake
//   command   action, number                      push / full
//   symbol    symbol, bit_value, last             pop / empty
//
// A power-on command yields 11 symbols and a show command 58 symbols. The
// back end emits one symbol per cycle while the output queue has room, and
// that sequencer sets the sustained rate. The front end splits a number into
// decimal digits, one per cycle, and hands them to a two-word job queue.
// Reset (rst, synchronous) empties both queues and returns both ends to idle.
// A stalled output queue stops only the back end; the front end keeps taking
// commands until the job queue fills.
module four_digit_segment_display_serializer
  import fss_pkg::*;
#(
  parameter int JOB_DEPTH = JOB_QUEUE_DEPTH,
  parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [15:0] number,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  symbol,
  output logic        bit_value,
  output logic        last
);

  // Front end to job queue.
  logic      job_push;
  job_t      job_wr;
  logic      job_full;

  // Job queue to back end.
  job_t      job_rd;
  logic      job_empty;
  logic      job_pop;

  // Back end to output queue.
  logic      out_push;
  sym_word_t out_word;
  logic      out_full;
  sym_word_t out_head;

  // The front end classifies each command and splits a show number into digits.
  fss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .action   (action),
    .number   (number),
    .full     (full),
    .job_push (job_push),
    .job      (job_wr),
    .job_full (job_full)
  );

  // The job queue lets the front end run ahead of a stalled back end.
  fss_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wr),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rd),
    .empty (job_empty)
  );

  // The back end turns each job into its line symbols.
  fss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job_rd),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_push  (out_push),
    .out_word  (out_word),
    .out_full  (out_full)
  );

  // The output queue holds finished symbols until the consumer pops them.
  fss_fifo #(
    .WIDTH ($bits(sym_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty)
  );

  assign symbol    = out_head.symbol;
  assign bit_value = out_head.bit_value;
  assign last      = out_head.last;

endmodule
